[hdl/assert_macros.svh]
// Assertion macros for the framer; clock clk and reset arst_n are assumed in scope.
// Compiled out when NO_ASSERTIONS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// expression must hold on every edge out of reset
`define CLPF_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("clpf assertion failed");
// antecedent implies consequent in the same cycle
`define CLPF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("clpf implication failed");
`else
`define CLPF_ASSERT(lbl, expr)
`define CLPF_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

[hdl/clpf_pkg.sv]
// Shared types, constants and the CRC byte update for the framer.
// No dependencies.
package clpf_pkg;

	localparam int STEPS_PER_BYTE = 32;
	localparam int MAX_RES        = 7;
	localparam int RES_CNT_W      = $clog2(MAX_RES + 1);
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_CAPACITY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_SEED     = 2'd3;

	localparam logic [7:0]  RST_MAX_PAYLOAD  = 8'd249;
	localparam logic [15:0] RST_OUT_CAPACITY = 16'hFFFF;
	localparam logic [31:0] RST_CRC_POLY     = 32'h04C1_1DB7;
	localparam logic [31:0] RST_CRC_SEED     = 32'hFFFF_FFFF;

	// action codes
	localparam logic ACT_START   = 1'b0;
	localparam logic ACT_PAYLOAD = 1'b1;

	// result status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_TOO_BIG  = 2'd1;
	localparam logic [1:0] STATUS_NO_ROOM  = 2'd2;
	localparam logic [1:0] STATUS_SEQ_ERR  = 2'd3;

	localparam logic [7:0]  LEN_OFFSET   = 8'd6;
	localparam logic [15:0] FRAME_EXTRA  = 16'd7;

	typedef struct packed {
		logic [7:0]  max_payload;
		logic [15:0] out_capacity;
		logic [31:0] poly;
		logic [31:0] seed;
	} cfg_t;

	// all result items of one input item, oldest in entry 0
	typedef struct packed {
		logic [MAX_RES-1:0][7:0] bytes;
		logic [RES_CNT_W-1:0]    cnt;
		logic [1:0]              status;
		logic                    last_flag;
	} frame_t;

	function automatic logic [31:0] crc_feed(logic [31:0] crc, logic [7:0] b,
		logic [31:0] poly);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < STEPS_PER_BYTE; k++) begin
			c = c[31] ? ((c << 1) ^ poly) : (c << 1);
		end
		return c;
	endfunction

endpackage

[hdl/clpf_item_if.sv]
// Input item channel: valid/ready plus the start and payload fields.
// Depends on clpf_pkg.
interface clpf_item_if import clpf_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] frame_type;
	logic [7:0] source_id;
	logic [7:0] payload_count;
	logic [7:0] data_byte;

	modport source (output valid, action, frame_type, source_id, payload_count, data_byte,
		input ready);
	modport sink (input valid, action, frame_type, source_id, payload_count, data_byte,
		output ready);
endinterface

[hdl/clpf_result_if.sv]
// Result item channel: valid/ready plus one wire byte, last flag and status.
// Depends on clpf_pkg.
interface clpf_result_if import clpf_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;
	logic [1:0] status;

	modport source (output valid, out_byte, last, status, input ready);
	modport sink (input valid, out_byte, last, status, output ready);
endinterface

[hdl/clpf_cfg_if.sv]
// Configuration write channel: valid/ready, register index and write data.
// Depends on clpf_pkg.
interface clpf_cfg_if import clpf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hdl/crc32_length_prefixed_framer.sv]
// Top level of the length-prefixed CRC32 frame builder.
// Depends on clpf_pkg, the three channel interfaces, clpf_cfg, clpf_engine, clpf_obuf.
//
// Usage:
//  item_in    - start items (header fields, payload length) and payload byte items.
//  result_out - one wire byte per item: LEN, TYPE, ECU_ID, payload echo, then the
//               CRC big-endian; last marks the final CRC byte and every error.
//  cfg        - register writes (max payload, capacity, polynomial, seed), always
//               ready; write only while the block is idle.
// An item is registered in the input register on acceptance; its results are built
// from that register and loaded into the result register once that is free, and
// the first result is valid from that load on.
// Throughput: one result item per cycle while the receiver is ready, set by the single
// result byte lane. An item giving one result (payload byte, error) can follow every
// cycle; an accepted start gives 3 or 7 result items, the last payload byte 5.
// The CRC per byte is one unrolled update; the TYPE byte is folded in at the
// input register so a start needs only one update in the frame stage.
// Reset clears the frame state (no frame open, CRC at 0xFFFFFFFF), empties both
// stages and restores the register defaults.
// Receiver stall: the result register holds its byte; one more item waits in the
// input register, after which item_in.ready drops until results drain.
`include "assert_macros.svh"

module crc32_length_prefixed_framer import clpf_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	clpf_item_if.sink      item_in,
	clpf_result_if.source  result_out,
	clpf_cfg_if.sink       cfg
);

	cfg_t   cfg_regs;
	frame_t frame;
	logic   eng_load;
	logic   eng_busy;
	logic   obuf_free;

	// register bank
	clpf_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_regs)
	);

	// input register, checks, CRC and frame state
	clpf_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_in),
		.regs      (cfg_regs),
		.obuf_free (obuf_free),
		.load      (eng_load),
		.busy      (eng_busy),
		.frame     (frame)
	);

	// result register and byte serialiser
	clpf_obuf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (eng_load),
		.frame  (frame),
		.free   (obuf_free),
		.res    (result_out)
	);

	// an error item is always a single, final result
	`CLPF_ASSERT_IMP(a_err_last, result_out.valid && result_out.status != STATUS_OK, result_out.last)
	// the result register is never overwritten while bytes remain
	`CLPF_ASSERT_IMP(a_load_free, eng_load, obuf_free)
	// input back-pressure only when the input register is occupied
	`CLPF_ASSERT_IMP(a_stall_busy, !item_in.ready, eng_busy)

endmodule

[hdl/clpf_cfg.sv]
// Configuration register bank of the framer.
// Depends on clpf_pkg and clpf_cfg_if.
module clpf_cfg import clpf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	clpf_cfg_if.sink  cfg,
	output cfg_t      regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.max_payload  <= RST_MAX_PAYLOAD;
			regs_q.out_capacity <= RST_OUT_CAPACITY;
			regs_q.poly         <= RST_CRC_POLY;
			regs_q.seed         <= RST_CRC_SEED;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MAX_PAYLOAD:  regs_q.max_payload  <= cfg.data[7:0];
				REG_OUT_CAPACITY: regs_q.out_capacity <= cfg.data[15:0];
				REG_CRC_POLY:     regs_q.poly         <= cfg.data;
				REG_CRC_SEED:     regs_q.seed         <= cfg.data;
				default:          regs_q              <= regs_q;
			endcase
		end
	end

endmodule

[hdl/clpf_engine.sv]
// Input register and frame logic: checks, header, payload echo, CRC and frame state.
// Depends on clpf_pkg and clpf_item_if.
module clpf_engine import clpf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	clpf_item_if.sink item,
	input  cfg_t      regs,
	input  logic      obuf_free,
	output logic      load,
	output logic      busy,
	output frame_t    frame
);

	// input stage
	logic        valid_s1;
	logic        action_s1;
	logic [7:0]  type_s1;
	logic [7:0]  src_s1;
	logic [7:0]  count_s1;
	logic [7:0]  data_s1;
	logic [31:0] crc_type_s1;   // seed already folded with TYPE

	// frame state
	logic [31:0] crc_q;
	logic [7:0]  left_q;
	logic        open_q;

	logic [31:0] crc_d;
	logic [7:0]  left_d;
	logic        open_d;
	logic [31:0] crc_in;
	logic [7:0]  byte_in;
	logic [31:0] crc_new;
	logic [15:0] frame_len;
	logic        accept;

	assign load       = valid_s1 && obuf_free;
	assign item.ready = !valid_s1 || load;
	assign accept     = item.valid && item.ready;
	assign busy       = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1   <= item.action;
			type_s1     <= item.frame_type;
			src_s1      <= item.source_id;
			count_s1    <= item.payload_count;
			data_s1     <= item.data_byte;
			crc_type_s1 <= crc_feed(regs.seed, item.frame_type, regs.poly);
		end
	end

	// one byte through the CRC: ECU_ID on start, payload byte otherwise
	assign crc_in    = (action_s1 == ACT_START) ? crc_type_s1 : crc_q;
	assign byte_in   = (action_s1 == ACT_START) ? src_s1 : data_s1;
	assign crc_new   = crc_feed(crc_in, byte_in, regs.poly);
	assign frame_len = {8'd0, count_s1} + FRAME_EXTRA;

	always_comb begin
		frame.bytes     = '0;
		frame.cnt       = RES_CNT_W'(1);
		frame.status    = STATUS_OK;
		frame.last_flag = 1'b0;
		crc_d           = crc_q;
		left_d          = left_q;
		open_d          = open_q;
		if (action_s1 == ACT_START) begin
			if (count_s1 > regs.max_payload) begin
				frame.status    = STATUS_TOO_BIG;
				frame.last_flag = 1'b1;
				open_d          = 1'b0;
				left_d          = 8'd0;
			end else if (frame_len > regs.out_capacity) begin
				frame.status    = STATUS_NO_ROOM;
				frame.last_flag = 1'b1;
				open_d          = 1'b0;
				left_d          = 8'd0;
			end else begin
				frame.bytes[0] = count_s1 + LEN_OFFSET;
				frame.bytes[1] = type_s1;
				frame.bytes[2] = src_s1;
				crc_d          = crc_new;
				if (count_s1 == 8'd0) begin
					frame.bytes[3]  = crc_new[31:24];
					frame.bytes[4]  = crc_new[23:16];
					frame.bytes[5]  = crc_new[15:8];
					frame.bytes[6]  = crc_new[7:0];
					frame.cnt       = RES_CNT_W'(7);
					frame.last_flag = 1'b1;
					open_d          = 1'b0;
					left_d          = 8'd0;
				end else begin
					frame.cnt = RES_CNT_W'(3);
					open_d    = 1'b1;
					left_d    = count_s1;
				end
			end
		end else if (!open_q || left_q == 8'd0) begin
			frame.status    = STATUS_SEQ_ERR;
			frame.last_flag = 1'b1;
		end else begin
			frame.bytes[0] = data_s1;
			crc_d          = crc_new;
			left_d         = left_q - 8'd1;
			if (left_q == 8'd1) begin
				frame.bytes[1]  = crc_new[31:24];
				frame.bytes[2]  = crc_new[23:16];
				frame.bytes[3]  = crc_new[15:8];
				frame.bytes[4]  = crc_new[7:0];
				frame.cnt       = RES_CNT_W'(5);
				frame.last_flag = 1'b1;
				open_d          = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= RST_CRC_SEED;
			left_q <= 8'd0;
			open_q <= 1'b0;
		end else if (load) begin
			crc_q  <= crc_d;
			left_q <= left_d;
			open_q <= open_d;
		end
	end

endmodule

[hdl/clpf_obuf.sv]
// Result register: holds the bytes of one item and hands them out one per cycle while the receiver is ready.
// Depends on clpf_pkg and clpf_result_if.
module clpf_obuf import clpf_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  frame_t        frame,
	output logic          free,
	clpf_result_if.source res
);

	logic [MAX_RES-1:0][7:0] bytes_q;
	logic [RES_CNT_W-1:0]    rem_q;
	logic [1:0]              status_q;
	logic                    last_flag_q;
	logic                    pop;

	assign pop          = res.valid && res.ready;
	assign free         = (rem_q == '0) || (rem_q == RES_CNT_W'(1) && res.ready);
	assign res.valid    = (rem_q != '0);
	assign res.out_byte = bytes_q[0];
	assign res.last     = last_flag_q && (rem_q == RES_CNT_W'(1));
	assign res.status   = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= frame.cnt;
		end else if (pop) begin
			rem_q <= rem_q - RES_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q     <= frame.bytes;
			status_q    <= frame.status;
			last_flag_q <= frame.last_flag;
		end else if (pop) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				bytes_q[i] <= bytes_q[i+1];
			end
			bytes_q[MAX_RES-1] <= '0;
		end
	end

endmodule

[sim/tb_top.sv]
// Self-checking bench for crc32_length_prefixed_framer: directed frames, then random phases.
// Depends on clpf_pkg, the item/result/cfg channel interfaces and the framer RTL.
`timescale 1ns / 1ps

module tb_top;
	import clpf_pkg::*;

	// one pending input item
	typedef struct {
		logic       act;
		logic [7:0] ftype;
		logic [7:0] src;
		logic [7:0] cnt;
		logic [7:0] data;
	} pend_item_t;

	// one predicted wire byte
	typedef struct packed {
		logic [7:0] data;
		logic       eof;
		logic [1:0] stat;
	} wire_byte_t;

	logic clk;
	logic arst_n;

	clpf_item_if   item_ch ();
	clpf_result_if res_ch ();
	clpf_cfg_if    cfg_ch ();

	crc32_length_prefixed_framer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_ch),
		.result_out (res_ch),
		.cfg        (cfg_ch)
	);

	pend_item_t pend_q[$];   // items waiting for the driver
	wire_byte_t wire_q[$];   // wire bytes the framer still owes us

	// shadow registers and frame state
	logic [7:0]  m_max;
	logic [15:0] m_cap;
	logic [31:0] m_poly;
	logic [31:0] m_seed;
	logic [31:0] m_crc;
	logic [7:0]  m_left;
	logic        m_open;

	int  tx_idle_pct;
	int  rx_stall_pct;
	bit  in_fire;      // item taken at the last rising edge
	int  err_count;
	int  queued;
	int  items_taken;
	int  bytes_checked;
	int  settings_used;

	// 20 ns clock, low first
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// one byte into the CRC: xor into the low bits, then MSB-first shift/poly steps
	function automatic logic [31:0] crc_next(logic [31:0] acc, logic [7:0] b);
		logic [31:0] r;
		int          i;
		r = acc ^ {24'h0, b};
		for (i = 0; i < STEPS_PER_BYTE; i++)
			r = {r[30:0], 1'b0} ^ (r[31] ? m_poly : 32'h0);
		return r;
	endfunction

	function automatic void owe(logic [7:0] d, logic e, logic [1:0] s);
		wire_byte_t w;
		w.data = d;
		w.eof  = e;
		w.stat = s;
		wire_q.push_back(w);
	endfunction

	// CRC trailer, big-endian, closes the frame
	function automatic void owe_crc();
		owe(m_crc[31:24], 1'b0, STATUS_OK);
		owe(m_crc[23:16], 1'b0, STATUS_OK);
		owe(m_crc[15:8], 1'b0, STATUS_OK);
		owe(m_crc[7:0], 1'b1, STATUS_OK);
		m_open = 1'b0;
		m_left = 8'd0;
	endfunction

	// work out the wire bytes caused by one accepted item
	function automatic void frame_predict(logic act, logic [7:0] ft, logic [7:0] sid,
		logic [7:0] cnt, logic [7:0] db);
		if (act == ACT_START) begin
			if (cnt > m_max) begin
				// too big is checked ahead of capacity; any open frame is dropped
				m_open = 1'b0;
				m_left = 8'd0;
				owe(8'd0, 1'b1, STATUS_TOO_BIG);
			end else if (int'(cnt) + 7 > int'(m_cap)) begin
				m_open = 1'b0;
				m_left = 8'd0;
				owe(8'd0, 1'b1, STATUS_NO_ROOM);
			end else begin
				// LEN wraps modulo 256 when max_payload is above 249
				owe(cnt + 8'd6, 1'b0, STATUS_OK);
				owe(ft, 1'b0, STATUS_OK);
				owe(sid, 1'b0, STATUS_OK);
				m_crc = crc_next(crc_next(m_seed, ft), sid);
				if (cnt == 8'd0) begin
					owe_crc();
				end else begin
					// a start mid-frame simply abandons the old one
					m_open = 1'b1;
					m_left = cnt;
				end
			end
		end else begin
			if (!m_open || m_left == 8'd0) begin
				// stray payload byte, state untouched
				owe(8'd0, 1'b1, STATUS_SEQ_ERR);
			end else begin
				owe(db, 1'b0, STATUS_OK);
				m_crc  = crc_next(m_crc, db);
				m_left = m_left - 8'd1;
				if (m_left == 8'd0)
					owe_crc();
			end
		end
	endfunction

	// ---- input side ----------------------------------------------------------

	always @(posedge clk) begin : item_capture
		in_fire = arst_n && item_ch.valid && item_ch.ready;
		if (in_fire) begin
			items_taken++;
			frame_predict(item_ch.action, item_ch.frame_type, item_ch.source_id,
				item_ch.payload_count, item_ch.data_byte);
		end
	end

	// holds an item until taken, then presents the next one or idles
	always @(negedge clk) begin : item_driver
		pend_item_t nxt;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else if (!item_ch.valid || in_fire) begin
			if (pend_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				nxt = pend_q.pop_front();
				item_ch.valid         <= 1'b1;
				item_ch.action        <= nxt.act;
				item_ch.frame_type    <= nxt.ftype;
				item_ch.source_id     <= nxt.src;
				item_ch.payload_count <= nxt.cnt;
				item_ch.data_byte     <= nxt.data;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// ---- output side ---------------------------------------------------------

	always @(negedge clk) begin : result_stall
		res_ch.ready <= arst_n && ($urandom_range(99) >= rx_stall_pct);
	end

	always @(posedge clk) begin : result_check
		wire_byte_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			bytes_checked++;
			if (wire_q.size() == 0) begin
				$error("unexpected result item: out_byte %0h last %0b status %0d",
					res_ch.out_byte, res_ch.last, res_ch.status);
				err_count++;
			end else begin
				want = wire_q.pop_front();
				if (res_ch.out_byte !== want.data) begin
					$error("out_byte: expected %0h actual %0h", want.data, res_ch.out_byte);
					err_count++;
				end
				if (res_ch.last !== want.eof) begin
					$error("last: expected %0b actual %0b", want.eof, res_ch.last);
					err_count++;
				end
				if (res_ch.status !== want.stat) begin
					$error("status: expected %0d actual %0d", want.stat, res_ch.status);
					err_count++;
				end
			end
		end
	end

	// ---- stimulus helpers ----------------------------------------------------

	task automatic push_start(input logic [7:0] ft, input logic [7:0] sid,
		input logic [7:0] c);
		pend_item_t it;
		it.act   = ACT_START;
		it.ftype = ft;
		it.src   = sid;
		it.cnt   = c;
		it.data  = 8'($urandom);  // ignored on a start
		pend_q.push_back(it);
		queued++;
	endtask

	task automatic push_payload(input logic [7:0] d);
		pend_item_t it;
		it.act   = ACT_PAYLOAD;
		it.ftype = 8'($urandom);  // header fields ignored on a payload byte
		it.src   = 8'($urandom);
		it.cnt   = 8'($urandom);
		it.data  = d;
		pend_q.push_back(it);
		queued++;
	endtask

	// everything sent has been taken and answered
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pend_q.size() != 0 || item_ch.valid || wire_q.size() != 0);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (idx)
			REG_MAX_PAYLOAD:  m_max  = val[7:0];
			REG_OUT_CAPACITY: m_cap  = val[15:0];
			REG_CRC_POLY:     m_poly = val;
			REG_CRC_SEED:     m_seed = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// all four registers; unused upper bits of the narrow ones get noise
	task automatic set_regs(input logic [7:0] mx, input logic [15:0] cap,
		input logic [31:0] poly, input logic [31:0] seed);
		logic [31:0] hi;
		hi = $urandom;
		cfg_write(REG_MAX_PAYLOAD, {hi[31:8], mx});
		cfg_write(REG_OUT_CAPACITY, {hi[15:0], cap});
		cfg_write(REG_CRC_POLY, poly);
		cfg_write(REG_CRC_SEED, seed);
		settings_used++;
	endtask

	// mostly whole frames with random content; some cut short, stray bytes, bad starts
	task automatic run_random(input int n);
		int first;
		int r;
		int lim;
		int c;
		int k;
		first = queued;
		while (queued - first < n) begin
			r   = $urandom_range(99);
			lim = (m_cap < 16'd7) ? -1 : ((int'(m_max) < int'(m_cap) - 7) ?
				int'(m_max) : int'(m_cap) - 7);
			if (r < 80) begin
				if (lim < 0)
					c = $urandom_range(255);
				else if ($urandom_range(39) == 0)
					c = $urandom_range(lim);
				else
					c = $urandom_range((lim < 12) ? lim : 12);
				push_start(8'($urandom), 8'($urandom), c[7:0]);
				// truncated frames get overrun by the next start; a refused start
				// is followed by only a few stray bytes
				if (lim < 0)
					k = $urandom_range(2);
				else
					k = (r < 70 || c == 0) ? c : $urandom_range(c - 1);
				repeat (k) push_payload(8'($urandom));
			end else if (r < 88) begin
				repeat ($urandom_range(1, 3)) push_payload(8'($urandom));
			end else begin
				push_start(8'($urandom), 8'($urandom), 8'($urandom_range(255)));
			end
		end
	endtask

	// ---- main sequence -------------------------------------------------------

	initial begin : main_seq
		int ph;
		logic [31:0] rv;

		// everything known from time zero
		arst_n                = 1'b0;
		item_ch.valid         = 1'b0;
		item_ch.action        = ACT_START;
		item_ch.frame_type    = 8'd0;
		item_ch.source_id     = 8'd0;
		item_ch.payload_count = 8'd0;
		item_ch.data_byte     = 8'd0;
		res_ch.ready          = 1'b0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.index          = REG_MAX_PAYLOAD;
		cfg_ch.data           = 32'd0;
		tx_idle_pct           = 0;
		rx_stall_pct          = 0;
		err_count             = 0;
		queued                = 0;
		items_taken           = 0;
		bytes_checked         = 0;
		settings_used         = 1;

		// shadow of the reset state
		m_max  = RST_MAX_PAYLOAD;
		m_cap  = RST_OUT_CAPACITY;
		m_poly = RST_CRC_POLY;
		m_seed = RST_CRC_SEED;
		m_crc  = RST_CRC_SEED;
		m_left = 8'd0;
		m_open = 1'b0;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed, reset defaults
		push_start(8'h00, 8'h00, 8'd0);        // empty payload, CRC straight away
		push_start(8'hFF, 8'hFF, 8'd0);
		push_payload(8'h5A);                   // stray byte, no frame open
		push_start(8'h3C, 8'hC3, 8'd2);
		push_payload(8'h00);
		push_payload(8'hFF);
		push_start(8'($urandom), 8'($urandom), 8'd250); // one over the limit
		push_start(8'($urandom), 8'($urandom), 8'd255);
		push_start(8'h12, 8'h34, 8'd3);
		push_payload(8'hA5);
		push_start(8'h56, 8'h78, 8'd1);        // abandons the frame above
		push_payload(8'h81);
		push_payload(8'h7E);                   // frame closed: sequence error
		wait_idle();

		// tight capacity: too big wins over no room, no room drops an open frame
		set_regs(8'd249, 16'd10, RST_CRC_POLY, RST_CRC_SEED);
		push_start(8'($urandom), 8'($urandom), 8'd250);
		push_start(8'($urandom), 8'($urandom), 8'd3);  // exactly fills 10 bytes
		push_payload(8'($urandom));
		push_start(8'($urandom), 8'($urandom), 8'd4);
		push_payload(8'($urandom));
		wait_idle();

		// raised payload limit: LEN wraps
		set_regs(8'd255, 16'hFFFF, RST_CRC_POLY, RST_CRC_SEED);
		push_start(8'($urandom), 8'($urandom), 8'd255);
		push_payload(8'($urandom));
		push_payload(8'($urandom));
		push_start(8'($urandom), 8'($urandom), 8'd0);
		wait_idle();

		// random phases, idling pattern cycles through the four modes
		for (ph = 0; ph < 8; ph++) begin
			rv = $urandom;
			case (ph)
				0: set_regs(8'd249, 16'hFFFF, $urandom, $urandom);
				1: set_regs(8'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
				2: set_regs(8'd255, 16'd262, $urandom, 32'hFFFF_FFFF);
				3: set_regs(rv[7:0], 16'd0, $urandom, $urandom);
				4: set_regs(8'd249, 16'd7, 32'h0, $urandom);
				5: set_regs(8'($urandom), 16'($urandom), $urandom, $urandom);
				6: set_regs(RST_MAX_PAYLOAD, RST_OUT_CAPACITY, RST_CRC_POLY, RST_CRC_SEED);
				default: set_regs(8'($urandom_range(30)), 16'($urandom_range(8, 40)),
					$urandom, $urandom);
			endcase
			case (ph % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 75; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 75; end
				default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
			endcase
			run_random(40);
			wait_idle();
		end

		// keep clocking a while longer in case anything extra trickles out
		repeat (8) @(posedge clk);

		$display("%0d items in, %0d wire bytes checked, %0d register settings",
			items_taken, bytes_checked, settings_used);
		if (err_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin : watchdog
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hdl
hdl/clpf_pkg.sv
hdl/clpf_item_if.sv
hdl/clpf_result_if.sv
hdl/clpf_cfg_if.sv
hdl/clpf_cfg.sv
hdl/clpf_engine.sv
hdl/clpf_obuf.sv
hdl/crc32_length_prefixed_framer.sv
sim/tb_top.sv
